// ===== sv/ttlc_pkg.sv =====
// Package for the TTL cache table: request codes, field widths and shared types.
// Used by the top level, controller and datapath of the ttl_cache_table_core hierarchy.
package ttlc_pkg;

    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 64;
    localparam int TTL_W    = 16;
    localparam int PLEN_W   = 4;
    localparam int REQ_W    = 3;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 7;
    localparam int CAP_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [TTL_W-1:0] FALLBACK_TTL = TTL_W'(60);
    localparam logic [TIME_W-1:0] TIME_TOP = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_GET    = 3'd0,
        REQ_SET    = 3'd1,
        REQ_DEL    = 3'd2,
        REQ_CLRPFX = 3'd3,
        REQ_CLRALL = 3'd4,
        REQ_TICK   = 3'd5
    } t_req;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_TTL  = 1'b1;

    // Scan passes the controller asks the datapath to run.
    typedef enum logic [2:0] {
        SCAN_FIND   = 3'd0,
        SCAN_PURGE  = 3'd1,
        SCAN_MIN    = 3'd2,
        SCAN_FREE   = 3'd3,
        SCAN_PREFIX = 3'd4
    } t_scan;

    typedef struct packed {
        logic  latch;      // capture the request
        logic  scan_start; // begin a pass at slot zero
        t_scan scan_kind;
        logic  drop_hit;   // drop the slot found by the find pass
        logic  drop_min;   // drop the earliest-expiry slot
        logic  write_new;  // write into found free slot
        logic  write_hit;  // write value and expiry into found slot
        logic  clear_all;
        logic  tick;
        logic  get_hit;    // latch read data as hit
        logic  set_found;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic hit;        // find pass found key
        logic hit_expired;
        logic full;       // count at or above effective capacity
        logic free_ok;    // free slot exists
        logic min_ok;
    } t_sts;

endpackage

// ===== sv/ttl_cache_table_core.sv =====
// Top level of the TTL cache table: stream ports, configuration registers,
// controller and datapath. Depends on ttlc_pkg, ttlc_ctrl, ttlc_datapath.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+------------------------------------
//  s_axis    | in        | tvalid / tready      | tdata: key, value, ttl, prefix_len; tuser: req_type
//  m_axis    | out       | tvalid / tready      | tdata: read_value, entry_count; tuser: found
//  cfg       | in        | valid / ready        | index, data
//
// Each table scan reads one slot per cycle from the slot memories. Get, delete and
// prefix clear run one find or prefix pass before their result; clear all and tick
// run no pass; a set runs one to four passes, four when it must evict.
// Synchronous active-low reset clears valid bits, time and count at once.
// The next request is taken once the previous result has been delivered.
module ttl_cache_table_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BYTES   = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: key[63:0], value[127:64], ttl[143:128], prefix_len[147:144]
    input  logic [151:0] s_axis_tdata,
    // tuser: req_type[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: read_value[63:0], entry_count[70:64]
    output logic [71:0]  m_axis_tdata,
    // tuser: found[0]
    output logic         m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [ttlc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ttlc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ttlc_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic [TTL_W-1:0] r_default_ttl;
    t_cmd cmd;
    t_sts sts;
    logic [CNT_W-1:0] cnt;
    logic [VALUE_W-1:0] rdv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity    <= CAP_W'(64);
            r_default_ttl <= TTL_W'(60);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CAPACITY: r_capacity <= i_cfg_data[CAP_W-1:0];
                CFG_DEF_TTL:  r_default_ttl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ttlc_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_req_type  (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ttlc_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BYTES(KEY_BYTES)) u_dp (
        .i_clk, .i_rst_n,
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_key         (s_axis_tdata[63:0]),
        .i_value       (s_axis_tdata[127:64]),
        .i_ttl         (s_axis_tdata[143:128]),
        .i_prefix_len  (s_axis_tdata[147:144]),
        .i_capacity    (r_capacity),
        .i_default_ttl (r_default_ttl),
        .o_found       (m_axis_tuser),
        .o_read_value  (rdv),
        .o_entry_count (cnt)
    );

    assign m_axis_tdata = {1'b0, cnt, rdv};

endmodule

// ===== sv/ttlc_datapath.sv =====
// Datapath of the TTL cache table: slot memories, valid bits, scan counter,
// time and count registers. Depends on ttlc_pkg.
module ttlc_datapath #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BYTES   = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ttlc_pkg::t_cmd                 i_cmd,
    output ttlc_pkg::t_sts                 o_sts,
    input  logic [ttlc_pkg::KEY_W-1:0]     i_key,
    input  logic [ttlc_pkg::VALUE_W-1:0]   i_value,
    input  logic [ttlc_pkg::TTL_W-1:0]     i_ttl,
    input  logic [ttlc_pkg::PLEN_W-1:0]    i_prefix_len,
    input  logic [ttlc_pkg::CAP_W-1:0]     i_capacity,
    input  logic [ttlc_pkg::TTL_W-1:0]     i_default_ttl,
    output logic                           o_found,
    output logic [ttlc_pkg::VALUE_W-1:0]   o_read_value,
    output logic [ttlc_pkg::CNT_W-1:0]     o_entry_count
);
    import ttlc_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int SCAN_W = IDX_W + 1;
    localparam int KB = KEY_BYTES * 8;

    logic [KEY_W-1:0]   mem_key [TABLE_DEPTH];
    logic [VALUE_W-1:0] mem_val [TABLE_DEPTH];
    logic [TIME_W-1:0]  mem_exp [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;

    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_pmask;
    logic [VALUE_W-1:0] r_value;
    logic [TIME_W-1:0]  r_new_exp;
    logic [TIME_W-1:0]  r_time;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_cap;

    // Scan: address stage then registered read then compare stage.
    logic               r_scan_run;
    t_scan              r_kind;
    logic [SCAN_W-1:0]  r_addr;
    logic               r_rd_v;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_rd_valid;
    logic [KEY_W-1:0]   r_rd_key;
    logic [TIME_W-1:0]  r_rd_exp;
    logic [VALUE_W-1:0] r_rd_val;
    logic               r_done;

    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic               r_hit_exp;
    logic [VALUE_W-1:0] r_hit_val;
    logic               r_free_ok;
    logic [IDX_W-1:0]   r_free_idx;
    logic               r_min_ok;
    logic [IDX_W-1:0]   r_min_idx;
    logic [TIME_W-1:0]  r_min_exp;

    logic               r_found;
    logic [VALUE_W-1:0] r_rdata;
    logic [CNT_W-1:0]   r_out_cnt;

    logic [KEY_W-1:0]   kmask;
    logic [KEY_W-1:0]   pmask;
    logic [3:0]         plen;
    logic [TTL_W-1:0]   life;
    logic [TIME_W:0]    exp_sum;
    logic [CAP_W-1:0]   cap_eff;
    logic               rd_expired;
    logic               drop_scan;
    logic [CNT_W-1:0]   n_count;

    always_comb begin
        kmask = (KB >= KEY_W) ? '1 : ((KEY_W'(1) << KB) - KEY_W'(1));
        plen = (i_prefix_len > PLEN_W'(KEY_BYTES)) ? 4'(KEY_BYTES) : i_prefix_len;
        pmask = kmask & ~((KEY_W'(1) << (7'(KEY_BYTES - int'(plen)) * 7'd8)) - KEY_W'(1));
        life = (i_ttl != '0) ? i_ttl : ((i_default_ttl != '0) ? i_default_ttl : FALLBACK_TTL);
        exp_sum = {1'b0, r_time} + (TIME_W+1)'(life);
        if (i_capacity == '0) cap_eff = CAP_W'(1);
        else if (32'(i_capacity) > TABLE_DEPTH) cap_eff = CAP_W'(TABLE_DEPTH);
        else cap_eff = i_capacity;
        rd_expired = r_time >= r_rd_exp;
    end

    // Purge and prefix passes drop slots as they stream through compare.
    always_comb begin
        drop_scan = 1'b0;
        if (r_rd_v && r_rd_valid) begin
            if (r_kind == SCAN_PURGE) drop_scan = rd_expired;
            if (r_kind == SCAN_PREFIX) drop_scan = ((r_rd_key ^ r_key) & r_pmask) == '0;
        end
    end

    always_comb begin
        n_count = r_count;
        if (drop_scan) n_count = r_count - CNT_W'(1);
        if (i_cmd.drop_hit || i_cmd.drop_min) n_count = r_count - CNT_W'(1);
        if (i_cmd.write_new) n_count = r_count + CNT_W'(1);
        if (i_cmd.clear_all) n_count = '0;
    end

    always_ff @(posedge i_clk) begin
        r_rd_key <= mem_key[r_addr[IDX_W-1:0]];
        r_rd_exp <= mem_exp[r_addr[IDX_W-1:0]];
        r_rd_val <= mem_val[r_addr[IDX_W-1:0]];
        if (i_cmd.write_new) begin
            mem_key[r_free_idx] <= r_key;
            mem_val[r_free_idx] <= r_value;
            mem_exp[r_free_idx] <= r_new_exp;
        end else if (i_cmd.write_hit) begin
            mem_val[r_hit_idx] <= r_value;
            mem_exp[r_hit_idx] <= r_new_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_key     <= i_key & kmask;
            r_pmask   <= pmask;
            r_value   <= i_value;
            r_new_exp <= exp_sum[TIME_W] ? TIME_TOP : exp_sum[TIME_W-1:0];
            r_cap     <= cap_eff;
        end
        r_rd_idx <= r_addr[IDX_W-1:0];
        if (r_rd_v) begin
            unique case (r_kind)
                SCAN_FIND: if (!r_hit && r_rd_valid && r_rd_key == r_key) begin
                    r_hit_idx <= r_rd_idx;
                    r_hit_exp <= rd_expired;
                    r_hit_val <= r_rd_val;
                end
                SCAN_FREE: if (!r_free_ok && !r_rd_valid) r_free_idx <= r_rd_idx;
                SCAN_MIN: if (r_rd_valid && (!r_min_ok || r_rd_exp < r_min_exp)) begin
                    r_min_idx <= r_rd_idx;
                    r_min_exp <= r_rd_exp;
                end
                default: ;
            endcase
        end
        if (i_cmd.out_load) begin
            r_rdata   <= i_cmd.get_hit ? r_hit_val : '0;
            r_out_cnt <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_time     <= '0;
            r_count    <= '0;
            r_scan_run <= 1'b0;
            r_kind     <= SCAN_FIND;
            r_addr     <= '0;
            r_rd_v     <= 1'b0;
            r_rd_valid <= 1'b0;
            r_done     <= 1'b0;
            r_hit      <= 1'b0;
            r_free_ok  <= 1'b0;
            r_min_ok   <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_rd_v <= r_scan_run;
            r_rd_valid <= r_valid[r_addr[IDX_W-1:0]];
            if (i_cmd.scan_start) begin
                r_scan_run <= 1'b1;
                r_kind     <= i_cmd.scan_kind;
                r_addr     <= '0;
                r_hit      <= (i_cmd.scan_kind == SCAN_FIND) ? 1'b0 : r_hit;
                r_free_ok  <= 1'b0;
                r_min_ok   <= 1'b0;
            end else if (r_scan_run) begin
                if (r_addr == SCAN_W'(TABLE_DEPTH - 1)) r_scan_run <= 1'b0;
                r_addr <= r_addr + SCAN_W'(1);
            end
            if (r_rd_v) begin
                if (!r_scan_run) r_done <= 1'b1;
                unique case (r_kind)
                    SCAN_FIND: if (r_rd_valid && r_rd_key == r_key) r_hit <= 1'b1;
                    SCAN_FREE: if (!r_rd_valid) r_free_ok <= 1'b1;
                    SCAN_MIN: if (r_rd_valid) r_min_ok <= 1'b1;
                    default: ;
                endcase
            end
            if (drop_scan) r_valid[r_rd_idx] <= 1'b0;
            if (i_cmd.drop_hit) r_valid[r_hit_idx] <= 1'b0;
            if (i_cmd.drop_min) r_valid[r_min_idx] <= 1'b0;
            if (i_cmd.write_new) r_valid[r_free_idx] <= 1'b1;
            if (i_cmd.clear_all) r_valid <= '0;
            if (i_cmd.tick && r_time != TIME_TOP) r_time <= r_time + TIME_W'(1);
            r_count <= n_count;
            if (i_cmd.out_load) r_found <= i_cmd.set_found;
        end
    end

    assign o_sts.scan_done   = r_done;
    assign o_sts.hit         = r_hit;
    assign o_sts.hit_expired = r_hit_exp;
    assign o_sts.full        = r_count >= r_cap;
    assign o_sts.free_ok     = r_free_ok;
    assign o_sts.min_ok      = r_min_ok;
    assign o_found       = r_found;
    assign o_read_value  = r_rdata;
    assign o_entry_count = r_out_cnt;

endmodule

// ===== sv/ttlc_ctrl.sv =====
// Controller of the TTL cache table: sequences scan passes per request.
// Depends on ttlc_pkg.
module ttlc_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ttlc_pkg::REQ_W-1:0] i_req_type,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output ttlc_pkg::t_cmd             o_cmd,
    input  ttlc_pkg::t_sts             i_sts
);
    import ttlc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_FIND_W, S_PURGE_W, S_MIN_W, S_FREE_W, S_PFX_W, S_OUT
    } t_state;

    t_state r_state;
    t_req   r_req;
    logic   r_out_valid;
    logic   r_evicted;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.scan_kind = SCAN_FIND;
        unique case (r_state)
            S_IDLE: if (i_in_valid && o_in_ready) o_cmd.latch = 1'b1;
            S_FIND: begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_kind = (r_req == REQ_CLRPFX) ? SCAN_PREFIX : SCAN_FIND;
            end
            S_FIND_W: if (i_sts.scan_done) begin
                if (r_req == REQ_SET) begin
                    if (i_sts.hit) o_cmd.write_hit = 1'b1;
                    else begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_kind = i_sts.full ? SCAN_PURGE : SCAN_FREE;
                    end
                end
            end
            S_PURGE_W: if (i_sts.scan_done && i_sts.full) begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_kind = SCAN_MIN;
            end else if (i_sts.scan_done) begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_kind = SCAN_FREE;
            end
            S_MIN_W: if (i_sts.scan_done && !r_evicted) begin
                o_cmd.drop_min = i_sts.min_ok;
            end else if (r_evicted) begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_kind = SCAN_FREE;
            end
            S_FREE_W: if (i_sts.scan_done) o_cmd.write_new = i_sts.free_ok;
            default: ;
        endcase
        // Result load: done in S_OUT, the cycle before the result is presented.
        if (r_state == S_OUT && !r_out_valid) begin
            o_cmd.out_load = 1'b1;
            unique case (r_req)
                REQ_GET: begin
                    o_cmd.get_hit   = i_sts.hit && !i_sts.hit_expired;
                    o_cmd.set_found = i_sts.hit && !i_sts.hit_expired;
                    o_cmd.drop_hit  = i_sts.hit && i_sts.hit_expired;
                end
                REQ_DEL: begin
                    o_cmd.set_found = i_sts.hit;
                    o_cmd.drop_hit  = i_sts.hit;
                end
                REQ_CLRALL: o_cmd.clear_all = 1'b1;
                REQ_CLRPFX: o_cmd.clear_all = 1'b0;
                REQ_TICK: o_cmd.tick = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req       <= REQ_GET;
            r_out_valid <= 1'b0;
            r_evicted   <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid && o_in_ready) begin
                    r_req <= t_req'(i_req_type);
                    r_evicted <= 1'b0;
                    if (i_req_type == REQ_GET || i_req_type == REQ_SET ||
                        i_req_type == REQ_DEL ||
                        i_req_type == REQ_CLRPFX) r_state <= S_FIND;
                    else r_state <= S_OUT;
                end
                S_FIND: r_state <= (r_req == REQ_CLRPFX) ? S_PFX_W : S_FIND_W;
                S_FIND_W: if (i_sts.scan_done) begin
                    if (r_req == REQ_SET && !i_sts.hit)
                        r_state <= i_sts.full ? S_PURGE_W : S_FREE_W;
                    else r_state <= S_OUT;
                end
                S_PURGE_W: if (i_sts.scan_done)
                    r_state <= i_sts.full ? S_MIN_W : S_FREE_W;
                S_MIN_W: begin
                    if (i_sts.scan_done) r_evicted <= 1'b1;
                    if (r_evicted) r_state <= S_FREE_W;
                end
                S_FREE_W: if (i_sts.scan_done) r_state <= S_OUT;
                S_PFX_W: if (i_sts.scan_done) r_state <= S_OUT;
                S_OUT: if (!r_out_valid) begin
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/ttlc_checker.sv =====
// Port-level checker for ttl_cache_table_core, attached by bind.
// Depends only on the top-level ports.
module ttlc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while result pending");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[70:64] <= 7'd64 || m_axis_tdata[70] == 1'b0)
        else $error("entry count out of range");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:0] == 64'd0)
        else $error("read value nonzero without hit");
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result before any work");
endmodule

bind ttl_cache_table_core ttlc_checker u_ttlc_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

// ===== tb/testbench.sv =====
// Self-checking testbench for ttl_cache_table_core: drives random and directed
// cache requests, predicts each response with a local table model and compares.
// Depends on ttlc_pkg and the ttl_cache_table_core RTL.
`timescale 1ns / 1ps

module testbench;
    import ttlc_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [TTL_W-1:0]   ttl;
        logic [PLEN_W-1:0]  plen;
    } cache_req_t;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] read_value;
        logic [CNT_W-1:0]   entry_count;
    } cache_resp_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ttl_cache_table_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Local copy of the cache state.
    bit                 slot_used [DEPTH];
    bit [KEY_W-1:0]     slot_k    [DEPTH];
    bit [VALUE_W-1:0]   slot_v    [DEPTH];
    bit [TIME_W-1:0]    slot_exp  [DEPTH];
    bit [TIME_W-1:0]    now_sec;
    int                 held;
    bit [CAP_W-1:0]     cap_reg;
    bit [TTL_W-1:0]     def_ttl_reg;

    cache_resp_t pending_results[$];
    int          fail_count;
    int          cycle_count;
    bit          quiet;          // no idling on either side while set
    int          drain_stall;
    logic [KEY_W-1:0] key_pool[];

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic int eff_cap();
        int c;
        c = cap_reg;
        if (c == 0) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    function automatic int find_slot(input bit [KEY_W-1:0] k);
        for (int i = 0; i < DEPTH; i++)
            if (slot_used[i] && slot_k[i] == k) return i;
        return -1;
    endfunction

    function automatic void drop(input int i);
        slot_used[i] = 1'b0;
        if (held > 0) held--;
    endfunction

    function automatic void wipe_all();
        for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
        held = 0;
    endfunction

    // Updates the cache state for one request and returns its response.
    function automatic cache_resp_t apply_to_cache(input cache_req_t r);
        cache_resp_t rsp;
        int          i;
        int          victim;
        bit [TTL_W-1:0]  life;
        bit [TIME_W:0]   sum;
        bit [TIME_W-1:0] exp_t;
        bit [KEY_W-1:0]  mask;
        int              nb;
        rsp = '0;
        case (r.req)
            REQ_GET: begin
                i = find_slot(r.key);
                if (i >= 0) begin
                    if (now_sec >= slot_exp[i]) drop(i);
                    else begin
                        rsp.found = 1'b1;
                        rsp.read_value = slot_v[i];
                    end
                end
            end
            REQ_SET: begin
                life = r.ttl;
                if (life == 0) life = def_ttl_reg;
                if (life == 0) life = FALLBACK_TTL;
                sum = {1'b0, now_sec} + life;
                exp_t = sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];
                i = find_slot(r.key);
                if (i < 0) begin
                    if (held >= eff_cap()) begin
                        for (int j = 0; j < DEPTH; j++)
                            if (slot_used[j] && now_sec >= slot_exp[j]) drop(j);
                        if (held >= eff_cap()) begin
                            victim = -1;
                            for (int j = 0; j < DEPTH; j++)
                                if (slot_used[j] &&
                                    (victim < 0 || slot_exp[j] < slot_exp[victim]))
                                    victim = j;
                            if (victim >= 0) drop(victim);
                        end
                    end
                    for (i = 0; i < DEPTH; i++)
                        if (!slot_used[i]) break;
                    if (i < DEPTH) begin
                        slot_used[i] = 1'b1;
                        slot_k[i] = r.key;
                        held++;
                    end
                end
                if (i < DEPTH) begin
                    slot_v[i] = r.value;
                    slot_exp[i] = exp_t;
                end
            end
            REQ_DEL: begin
                i = find_slot(r.key);
                if (i >= 0) begin
                    drop(i);
                    rsp.found = 1'b1;
                end
            end
            REQ_CLRPFX: begin
                if (r.plen == 0) wipe_all();
                else begin
                    nb = (r.plen > 8) ? 8 : r.plen;
                    mask = ~64'd0 << (8 * (8 - nb));
                    for (int j = 0; j < DEPTH; j++)
                        if (slot_used[j] && ((slot_k[j] ^ r.key) & mask) == 0) drop(j);
                end
            end
            REQ_CLRALL: wipe_all();
            REQ_TICK: if (now_sec != TIME_TOP) now_sec++;
            default: ;
        endcase
        rsp.entry_count = held[CNT_W-1:0];
        return rsp;
    endfunction

    // Sends one request; returns at the falling edge after the transaction with
    // tvalid still high, so a back-to-back request needs no second assignment.
    task automatic issue_request(input cache_req_t r);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {4'b0, r.plen, r.ttl, r.value, r.key};
        s_axis_tuser  <= r.req;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_to_cache(r));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_CAPACITY) cap_reg = data[CAP_W-1:0];
        else def_ttl_reg = data[TTL_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic cache_req_t make_req(input logic [REQ_W-1:0] req,
                                            input logic [KEY_W-1:0] key,
                                            input logic [VALUE_W-1:0] value,
                                            input logic [TTL_W-1:0] ttl,
                                            input logic [PLEN_W-1:0] plen);
        cache_req_t r;
        r.req = req; r.key = key; r.value = value; r.ttl = ttl; r.plen = plen;
        return r;
    endfunction

    // Keys share a few two-byte prefixes so that prefix clears hit groups.
    task automatic build_pool(input int n);
        logic [15:0] heads[4];
        foreach (heads[h]) heads[h] = 16'($urandom);
        key_pool = new[n];
        foreach (key_pool[i])
            key_pool[i] = {heads[$urandom_range(0, 3)], 16'($urandom), 32'($urandom)};
    endtask

    task automatic run_random(input int n_items, input int set_pct, input int ttl_max);
        cache_req_t r;
        int pick;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            r.key = ($urandom_range(0, 19) == 0) ? {32'($urandom), 32'($urandom)}
                    : key_pool[$urandom_range(0, key_pool.size() - 1)];
            r.value = {32'($urandom), 32'($urandom)};
            r.ttl = ($urandom_range(0, 24) == 0) ? TTL_W'($urandom)
                    : TTL_W'($urandom_range(0, ttl_max));
            r.plen = PLEN_W'($urandom_range(0, 15));
            if (pick < set_pct) r.req = REQ_SET;
            else if (pick < set_pct + (100 - set_pct) / 2) r.req = REQ_GET;
            else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6: r.req = REQ_TICK;
                    7, 8, 9, 10, 11:     r.req = REQ_DEL;
                    12, 13, 14:          r.req = REQ_CLRPFX;
                    15:                  r.req = REQ_CLRALL;
                    16:                  r.req = REQ_SPARE6;
                    17:                  r.req = REQ_SPARE7;
                    default:             r.req = REQ_GET;
                endcase
            end
            issue_request(r);
        end
    endtask

    task automatic test_directed();
        logic [KEY_W-1:0] ka, kb;
        ka = 64'h0123_4567_89AB_CDEF;
        kb = 64'h0123_4500_0000_0001;
        issue_request(make_req(REQ_GET, ka, '0, '0, '0));
        issue_request(make_req(REQ_SET, ka, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, '0));
        issue_request(make_req(REQ_GET, ka, '0, '0, '0));
        issue_request(make_req(REQ_SET, ka, 64'h0, 16'hFFFF, 4'hF));
        issue_request(make_req(REQ_GET, ka, '1, '1, '0));
        issue_request(make_req(REQ_SET, '1, 64'hA5A5_5A5A_0F0F_F0F0, 16'd1, '0));
        issue_request(make_req(REQ_SET, '0, 64'h1, 16'd2, '0));
        issue_request(make_req(REQ_SET, kb, 64'h2, 16'd1, '0));
        issue_request(make_req(REQ_TICK, '0, '0, '0, '0));
        // Entries with a one-second lifetime are now expired.
        issue_request(make_req(REQ_GET, '1, '0, '0, '0));
        issue_request(make_req(REQ_DEL, kb, '0, '0, '0));
        issue_request(make_req(REQ_DEL, kb, '0, '0, '0));
        issue_request(make_req(REQ_SET, kb, 64'h3, 16'd9, '0));
        issue_request(make_req(REQ_CLRPFX, ka, '0, '0, 4'd3));
        issue_request(make_req(REQ_SET, ka, 64'h4, 16'd9, '0));
        issue_request(make_req(REQ_CLRPFX, ka ^ 64'h1, '0, '0, 4'd9));
        issue_request(make_req(REQ_CLRPFX, ka, '0, '0, 4'd8));
        issue_request(make_req(REQ_SET, kb, 64'h5, 16'd9, '0));
        issue_request(make_req(REQ_CLRPFX, '0, '0, '0, 4'd0));
        issue_request(make_req(REQ_SET, ka, 64'h6, 16'd9, '0));
        issue_request(make_req(REQ_CLRALL, '0, '0, '0, '0));
        issue_request(make_req(REQ_SPARE6, ka, '1, '1, '1));
        issue_request(make_req(REQ_SPARE7, ka, '1, '1, '1));
    endtask

    task automatic test_small_capacity();
        write_reg(CFG_CAPACITY, 16'd4);
        write_reg(CFG_DEF_TTL, 16'd3);
        build_pool(10);
        run_random(250, 45, 8);
    endtask

    task automatic test_single_slot();
        write_reg(CFG_CAPACITY, 16'd1);
        write_reg(CFG_DEF_TTL, 16'd1);
        quiet = 1'b1;
        run_random(100, 45, 4);
        quiet = 1'b0;
        write_reg(CFG_CAPACITY, 16'd0);
        run_random(60, 45, 4);
    endtask

    task automatic test_full_depth();
        write_reg(CFG_CAPACITY, 16'hFFFF);
        write_reg(CFG_DEF_TTL, 16'hFFFF);
        build_pool(90);
        run_random(250, 75, 200);
    endtask

    // Lowering the limit below the current fill leaves the count above it.
    task automatic test_capacity_drop();
        write_reg(CFG_CAPACITY, 16'd64);
        build_pool(30);
        run_random(60, 90, 300);
        write_reg(CFG_CAPACITY, 16'd2);
        run_random(100, 50, 6);
    endtask

    task automatic test_default_ttl_zero();
        write_reg(CFG_CAPACITY, 16'd16);
        write_reg(CFG_DEF_TTL, 16'd0);
        build_pool(24);
        run_random(150, 50, 3);
    endtask

    // Response side: random stalls on tready, checks at the rising edge.
    always @(negedge i_clk) begin
        if (drain_stall > 0) begin
            m_axis_tready <= 1'b0;
            drain_stall--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cache_resp_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            drain_stall = quiet ? 0 : $urandom_range(0, 7);
            if (pending_results.size() == 0) begin
                report_mismatch("response with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.found)
                    report_mismatch($sformatf("found %b, expected %b",
                                              m_axis_tuser, want.found));
                if (m_axis_tdata[63:0] !== want.read_value)
                    report_mismatch($sformatf("read_value %h, expected %h",
                                              m_axis_tdata[63:0], want.read_value));
                if (m_axis_tdata[70:64] !== want.entry_count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              m_axis_tdata[70:64], want.entry_count));
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        fail_count = 0;
        cycle_count = 0;
        quiet = 1'b0;
        drain_stall = 0;
        for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
        now_sec = '0;
        held = 0;
        cap_reg = 7'd64;
        def_ttl_reg = 16'd60;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_small_capacity();
        test_single_slot();
        test_full_depth();
        test_capacity_drop();
        test_default_ttl_zero();

        wait_idle();
        repeat (300) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
